### rtl/lprt_pkg.sv
`timescale 1ns / 1ps

package lprt_pkg;

  localparam int TABLE_ENTRIES = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // stored route, valid bit kept apart
  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [3:0]  iface;
    logic [5:0]  ones;
  } route_t;

  // what a cell hands back to its left neighbor on remove
  typedef struct packed {
    logic   valid;
    route_t route;
  } slot_t;

  // request walking down the chain, one cell per cycle
  typedef struct packed {
    logic        active;
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [3:0]  iface;
    logic [5:0]  ones;
    logic        hit;
    logic [31:0] best_hop;
    logic [3:0]  best_iface;
    logic [5:0]  best_ones;
  } token_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

  function automatic logic [5:0] ones32(input logic [31:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, ones8(v[7:0])} + {1'b0, ones8(v[15:8])};
    hi = {1'b0, ones8(v[23:16])} + {1'b0, ones8(v[31:24])};
    return {1'b0, lo} + {1'b0, hi};
  endfunction

endpackage

### rtl/lprt_cell.sv
`timescale 1ns / 1ps

module lprt_cell
  import lprt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  token_t tok_in,
  input  slot_t  nb_in,
  output slot_t  slot_out,
  output token_t tok_out
);

  logic   valid;
  logic   valid_next;
  route_t route;
  route_t route_next;
  token_t tok_next;
  logic   rm_match;
  logic   lk_match;

  assign slot_out.valid = valid;
  assign slot_out.route = route;

  assign rm_match = valid && (route.net == tok_in.addr) && (route.mask == tok_in.mask);
  assign lk_match = valid && ((tok_in.addr & route.mask) == route.net);

  always_comb begin
    valid_next = valid;
    route_next = route;
    tok_next   = tok_in;
    if (tok_in.active) begin
      unique case (tok_in.cmd)
        CMD_ADD: begin
          // first free slot takes the route
          if (!tok_in.hit && !valid) begin
            valid_next       = 1'b1;
            route_next.net   = tok_in.addr;
            route_next.mask  = tok_in.mask;
            route_next.hop   = tok_in.hop;
            route_next.iface = tok_in.iface;
            route_next.ones  = tok_in.ones;
            tok_next.hit     = 1'b1;
          end
        end
        CMD_REMOVE: begin
          // from the first match onward every slot pulls its right neighbor
          if (tok_in.hit || rm_match) begin
            valid_next   = nb_in.valid;
            route_next   = nb_in.route;
            tok_next.hit = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (lk_match && (!tok_in.hit || route.ones > tok_in.best_ones)) begin
            tok_next.hit        = 1'b1;
            tok_next.best_hop   = route.hop;
            tok_next.best_iface = route.iface;
            tok_next.best_ones  = route.ones;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      valid          <= valid_next;
      tok_out.active <= tok_next.active;
    end
  end

  always_ff @(posedge clk) begin
    route      <= route_next;
    tok_out.cmd        <= tok_next.cmd;
    tok_out.addr       <= tok_next.addr;
    tok_out.mask       <= tok_next.mask;
    tok_out.hop        <= tok_next.hop;
    tok_out.iface      <= tok_next.iface;
    tok_out.ones       <= tok_next.ones;
    tok_out.hit        <= tok_next.hit;
    tok_out.best_hop   <= tok_next.best_hop;
    tok_out.best_iface <= tok_next.best_iface;
    tok_out.best_ones  <= tok_next.best_ones;
  end

endmodule

### rtl/longest_prefix_route_table.sv
`timescale 1ns / 1ps
// channel  signals                                          direction
// in       in_valid in_ready command address net_mask       into block
//          gateway iface_in
// out      out_valid out_ready status hop_out iface_out     out of block
//          prefix_ones
//
// one transaction at a time: a request walks the chain of TABLE_ENTRIES cells, one cell
// per cycle, through the seed register, the cells and the finish register, and a new
// request is taken once the previous result has reached the output register
// reset empties the table (valid bits only)
// a stalled output holds its result; the next request may enter and walk the chain
// meanwhile and then waits in the finish register

module longest_prefix_route_table
  import lprt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] net_mask,
  input  logic [31:0] gateway,
  input  logic [3:0]  iface_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] hop_out,
  output logic [3:0]  iface_out,
  output logic [5:0]  prefix_ones
);

  // request in flight anywhere between input and output register
  logic   busy;
  // request seed feeding the first cell
  token_t seed;
  // token leaving the last cell, parked until the output register is free
  token_t fin;
  logic   fin_pend;
  logic   fin_move;
  logic   in_fire;

  token_t tok   [TABLE_ENTRIES+1];
  slot_t  slots [TABLE_ENTRIES+1];

  logic [1:0]  res_status;
  logic [31:0] res_hop;
  logic [3:0]  res_iface;
  logic [5:0]  res_ones;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign fin_move = fin_pend && (!out_valid || out_ready);

  assign tok[0] = seed;
  // past the last cell nothing is stored
  assign slots[TABLE_ENTRIES].valid = 1'b0;
  assign slots[TABLE_ENTRIES].route = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lprt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .nb_in    (slots[i+1]),
      .slot_out (slots[i]),
      .tok_out  (tok[i+1])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      seed.active <= 1'b0;
      fin_pend    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      seed.active <= in_fire;
      if (in_fire) begin
        busy <= 1'b1;
      end else if (fin_move) begin
        busy <= 1'b0;
      end
      if (tok[TABLE_ENTRIES].active) begin
        fin_pend <= 1'b1;
      end else if (fin_move) begin
        fin_pend <= 1'b0;
      end
      if (fin_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // seed payload, mask one-count taken here once
  always_ff @(posedge clk) begin
    if (in_fire) begin
      seed.cmd        <= command;
      seed.addr       <= address;
      seed.mask       <= net_mask;
      seed.hop        <= gateway;
      seed.iface      <= iface_in;
      seed.ones       <= ones32(net_mask);
      seed.hit        <= 1'b0;
      seed.best_hop   <= '0;
      seed.best_iface <= '0;
      seed.best_ones  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[TABLE_ENTRIES].active) begin
      fin <= tok[TABLE_ENTRIES];
    end
  end

  // result from the finished token
  always_comb begin
    res_status = ST_OK;
    res_hop    = '0;
    res_iface  = '0;
    res_ones   = '0;
    unique case (fin.cmd)
      CMD_ADD: begin
        if (!fin.hit) begin
          res_status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (!fin.hit) begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        if (fin.hit) begin
          res_hop   = fin.best_hop;
          res_iface = fin.best_iface;
          res_ones  = fin.best_ones;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      status      <= res_status;
      hop_out     <= res_hop;
      iface_out   <= res_iface;
      prefix_ones <= res_ones;
    end
  end

endmodule
